/* rtl/ppct_pkg.sv */
// shared constants, types and the edge test for the point-in-polygon crossing test
// no dependencies; imported by the top level, the checker and the testbench

package ppct_pkg;

   // coordinate width, two's complement q12.4 at the default width
   localparam int COORD_WIDTH = 16;

   // stream packing
   localparam int REQ_FIELD_W = 4 * COORD_WIDTH;
   localparam int REQ_DATA_W  = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W = 3;
   localparam int RSP_DATA_W  = 8;

   // vertex counter, saturating
   localparam logic [1:0] COUNT_NONE = 2'd0;
   localparam logic [1:0] COUNT_ONE  = 2'd1;
   localparam logic [1:0] COUNT_FULL = 2'd3;

   typedef logic signed [COORD_WIDTH-1:0]   coord_type;
   typedef logic signed [COORD_WIDTH:0]     diff_type;
   typedef logic signed [2*COORD_WIDTH+1:0] prod_type;

   // outcome of one edge test
   typedef struct packed {
      logic hit;
      logic toggle;
   } edge_res_type;

   // test edge a-b against point p: boundary hit, or ray towards +x crosses
   function automatic edge_res_type ppct_edge_test(
      input coord_type px, input coord_type py,
      input coord_type ax, input coord_type ay,
      input coord_type bx, input coord_type by
   );
      edge_res_type res;
      coord_type    lo_x, hi_x, lo_y, hi_y;
      coord_type    lx, ly, ux, uy;
      diff_type     dx1, dy1, dx2, dy2;
      prod_type     lhs, rhs;
      logic         vert_hit, horiz_hit, axis_hit, straddle;

      lo_x = (ax < bx) ? ax : bx;
      hi_x = (ax < bx) ? bx : ax;
      lo_y = (ay < by) ? ay : by;
      hi_y = (ay < by) ? by : ay;

      // point equal to an endpoint
      vert_hit  = ((ax == px) && (ay == py)) || ((bx == px) && (by == py));
      // point strictly inside a horizontal or a vertical edge
      horiz_hit = (ay == by) && (ay == py) && (px > lo_x) && (px < hi_x);
      axis_hit  = (ax == bx) && (ax == px) && (py > lo_y) && (py < hi_y);

      // edge oriented with its lower endpoint first
      lx = (ay < by) ? ax : bx;
      ly = (ay < by) ? ay : by;
      ux = (ay < by) ? bx : ax;
      uy = (ay < by) ? by : ay;

      dx1 = {px[COORD_WIDTH-1], px} - {lx[COORD_WIDTH-1], lx};
      dy1 = {uy[COORD_WIDTH-1], uy} - {ly[COORD_WIDTH-1], ly};
      dx2 = {ux[COORD_WIDTH-1], ux} - {lx[COORD_WIDTH-1], lx};
      dy2 = {py[COORD_WIDTH-1], py} - {ly[COORD_WIDTH-1], ly};

      // exact comparison of the crossing abscissa, two independent products
      lhs = dx1 * dy1;
      rhs = dx2 * dy2;

      straddle   = (ay > py) != (by > py);
      res.hit    = vert_hit || horiz_hit || axis_hit;
      res.toggle = !res.hit && straddle && (lhs < rhs);
      return res;
   endfunction

endpackage

/* rtl/polygon_point_crossing_test.sv */
// point-in-polygon test by ray casting, one vertex per transfer
// a last vertex passes the input register and the edge-test stage into the result register
// throughput: one vertex per cycle, set by the single edge-test stage after the
// input register; a last vertex waits there only while a result is still untaken
// reset: synchronous, active high; clears the pipeline valids, the vertex
// count, the parity and boundary flags and the stored vertices
// depends on ppct_pkg

module polygon_point_crossing_test
   import ppct_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // point_x, point_y, vertex_x, vertex_y from the lowest bit up
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // first_vertex
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // inside_res, on_boundary, too_few_vertices from the lowest bit up, zero filled
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // input register
   logic      in_valid_ff;
   coord_type px_ff, py_ff, vx_ff, vy_ff;
   logic      first_ff, last_ff;

   // polygon state
   coord_type  start_x_ff, start_y_ff, prev_x_ff, prev_y_ff;
   logic       parity_ff, hit_ff;
   logic [1:0] count_ff;

   // result register
   logic                   rsp_valid_ff;
   logic [RSP_FIELD_W-1:0] rsp_ff;

   // next values
   coord_type              start_x_in, start_y_in;
   logic                   parity_in, hit_in;
   logic [1:0]             count_in;
   logic [RSP_FIELD_W-1:0] rsp_in;

   logic         step_go, restart, closing;
   logic         parity_step, hit_step;
   logic [1:0]   count_step;
   edge_res_type edge_cur, edge_close;

   // the stage advances unless a last vertex meets a result that stays put
   assign step_go    = in_valid_ff && (!last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_go;

   // input register load
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         px_ff    <= req_tdata[COORD_WIDTH-1:0];
         py_ff    <= req_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
         vx_ff    <= req_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
         vy_ff    <= req_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH];
         first_ff <= req_tuser;
         last_ff  <= req_tlast;
      end
   end

   // edge from the previous vertex, and closing edge back to the start
   assign edge_cur   = ppct_edge_test(px_ff, py_ff, vx_ff, vy_ff, prev_x_ff, prev_y_ff);
   assign edge_close = ppct_edge_test(px_ff, py_ff, start_x_ff, start_y_ff, vx_ff, vy_ff);

   // state and result update for the vertex in the stage
   always_comb begin
      restart     = first_ff || (count_ff == COUNT_NONE);
      start_x_in  = restart ? vx_ff : start_x_ff;
      start_y_in  = restart ? vy_ff : start_y_ff;
      parity_step = restart ? 1'b0 : (parity_ff ^ edge_cur.toggle);
      hit_step    = restart ? 1'b0 : (hit_ff | edge_cur.hit);
      if (restart) begin
         count_step = COUNT_ONE;
      end else if (count_ff == COUNT_FULL) begin
         count_step = COUNT_FULL;
      end else begin
         count_step = count_ff + 2'd1;
      end
      closing = (count_step == COUNT_FULL);
      rsp_in  = '0;
      if (closing) begin
         rsp_in[1] = hit_step | edge_close.hit;
         rsp_in[0] = rsp_in[1] | (parity_step ^ edge_close.toggle);
      end else begin
         rsp_in[2] = 1'b1;
      end
      // a last vertex ends the polygon
      if (last_ff) begin
         count_in  = COUNT_NONE;
         parity_in = 1'b0;
         hit_in    = 1'b0;
      end else begin
         count_in  = count_step;
         parity_in = parity_step;
         hit_in    = hit_step;
      end
   end

   // polygon state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= COUNT_NONE;
         parity_ff  <= 1'b0;
         hit_ff     <= 1'b0;
         start_x_ff <= '0;
         start_y_ff <= '0;
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
      end else if (step_go) begin
         count_ff   <= count_in;
         parity_ff  <= parity_in;
         hit_ff     <= hit_in;
         start_x_ff <= start_x_in;
         start_y_ff <= start_y_in;
         prev_x_ff  <= vx_ff;
         prev_y_ff  <= vy_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_go && last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (step_go && last_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-RSP_FIELD_W){1'b0}}, rsp_ff};

endmodule

/* rtl/ppct_checker.sv */
// port-level checks for the point-in-polygon crossing test
// depends on ppct_pkg; bound to polygon_point_crossing_test

module ppct_checker
   import ppct_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // a boundary hit always counts as inside
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[0])
      else $error("boundary result without inside");

   // a degenerate polygon reports neither inside nor boundary
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> !rsp_tdata[0] && !rsp_tdata[1])
      else $error("too few vertices with inside or boundary set");

   // an idle output frees the input side
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !req_tvalid |=> req_tready)
      else $error("input blocked with nothing pending");

endmodule

bind polygon_point_crossing_test ppct_checker u_ppct_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* tb/tb.sv */
// self-checking testbench for the point-in-polygon crossing test
// drives polygons vertex by vertex, predicts each verdict and checks the result stream
// depends on ppct_pkg and polygon_point_crossing_test

module tb;
   import ppct_pkg::*;

   // one vertex transfer as the driver sees it
   typedef struct {
      coord_type px;
      coord_type py;
      coord_type vx;
      coord_type vy;
      logic      first;
      logic      last;
   } vertex_item_type;

   // verdict packed as on rsp_tdata, lowest bit last in the list
   typedef struct packed {
      logic too_few;
      logic on_bnd;
      logic in_poly;
   } verdict_type;

   localparam int END_PAUSE  = 10;
   localparam int STALL_MAX  = 2000;
   localparam int CALM_FROM  = 500;
   localparam int CALM_UNTIL = 1000;
   localparam int ITEM_TOTAL = 1400;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // point_x, point_y, vertex_x, vertex_y from the lowest bit up
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // first_vertex
   logic                  req_tuser = 1'b0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // inside_res, on_boundary, too_few_vertices from the lowest bit up
   logic [RSP_DATA_W-1:0] rsp_tdata;

   vertex_item_type vertex_q[$];
   verdict_type     verdict_q[$];
   int              fail_cnt = 0;
   int              cycle_cnt = 0;
   int              stall_cnt = 0;
   logic            calm;

   // predictor state
   coord_type  ring_start_x = '0;
   coord_type  ring_start_y = '0;
   coord_type  ring_prev_x = '0;
   coord_type  ring_prev_y = '0;
   logic       ray_parity = 1'b0;
   logic       edge_touch = 1'b0;
   logic [1:0] ring_count = COUNT_NONE;

   polygon_point_crossing_test dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // no idling at all inside the calm window
   assign calm = (cycle_cnt >= CALM_FROM) && (cycle_cnt < CALM_UNTIL);

   function automatic bit idle_now();
      return !calm && ($urandom_range(0, 99) < 7);
   endfunction

   // one edge a-b against point p: boundary touch, else ray crossing towards +x
   function automatic void ray_edge_update(input longint px, input longint py,
                                           input longint ax, input longint ay,
                                           input longint bx, input longint by);
      longint lx, ly, ux, uy;
      if ((ax == px && ay == py) || (bx == px && by == py)) begin
         edge_touch = 1'b1;
         return;
      end
      if (ay == by && ay == py && px > ((ax < bx) ? ax : bx) && px < ((ax < bx) ? bx : ax))
      begin
         edge_touch = 1'b1;
         return;
      end
      if (ax == bx && ax == px && py > ((ay < by) ? ay : by) && py < ((ay < by) ? by : ay))
      begin
         edge_touch = 1'b1;
         return;
      end
      if ((ay > py) != (by > py)) begin
         lx = (ay < by) ? ax : bx;
         ly = (ay < by) ? ay : by;
         ux = (ay < by) ? bx : ax;
         uy = (ay < by) ? by : ay;
         if ((px - lx) * (uy - ly) < (ux - lx) * (py - ly))
            ray_parity = ~ray_parity;
      end
   endfunction

   // advance the polygon state by one vertex, queue a verdict on the last one
   function automatic void polygon_vertex_accept(input coord_type px, input coord_type py,
                                                 input coord_type vx, input coord_type vy,
                                                 input logic first, input logic last);
      verdict_type v;
      if (first || ring_count == COUNT_NONE) begin
         ring_start_x = vx;
         ring_start_y = vy;
         ray_parity   = 1'b0;
         edge_touch   = 1'b0;
         ring_count   = COUNT_ONE;
      end else begin
         ray_edge_update(px, py, vx, vy, ring_prev_x, ring_prev_y);
         if (ring_count != COUNT_FULL)
            ring_count = ring_count + 2'd1;
      end
      ring_prev_x = vx;
      ring_prev_y = vy;
      if (last) begin
         if (ring_count != COUNT_FULL) begin
            v = '{too_few: 1'b1, on_bnd: 1'b0, in_poly: 1'b0};
         end else begin
            ray_edge_update(px, py, ring_start_x, ring_start_y, vx, vy);
            v = '{too_few: 1'b0, on_bnd: edge_touch, in_poly: edge_touch | ray_parity};
         end
         verdict_q.insert(verdict_q.size(), v);
         ring_count = COUNT_NONE;
         ray_parity = 1'b0;
         edge_touch = 1'b0;
      end
   endfunction

   task automatic add_vertex(input int px, input int py, input int vx, input int vy,
                             input bit first, input bit last);
      vertex_item_type it;
      it.px    = coord_type'(px);
      it.py    = coord_type'(py);
      it.vx    = coord_type'(vx);
      it.vy    = coord_type'(vy);
      it.first = first;
      it.last  = last;
      vertex_q.insert(vertex_q.size(), it);
   endtask

   // span 0 means the full coordinate range
   function automatic int rand_coord(input int span);
      if (span == 0)
         return int'(coord_type'($urandom));
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic int near(input int c);
      return int'(coord_type'(c + int'($urandom_range(0, 2)) - 1));
   endfunction

   // one polygon, sometimes rectilinear, with the point placed at random, on a vertex or near its vertices
   task automatic add_polygon();
      int n, span, mode, sel, px, py, hop;
      int vx[8], vy[8];
      bit rect;
      sel  = $urandom_range(0, 9);
      span = (sel < 7) ? 64 : (sel < 9) ? 2048 : 0;
      n    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
      rect = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < n; i++) begin
         vx[i] = rand_coord(span);
         vy[i] = rand_coord(span);
         if (rect && i > 0) begin
            if (i % 2) vy[i] = vy[i-1];
            else       vx[i] = vx[i-1];
         end
      end
      mode = $urandom_range(0, 3);
      case (mode)
         0: begin
            px = rand_coord(span);
            py = rand_coord(span);
         end
         1: begin
            sel = $urandom_range(0, n - 1);
            px  = vx[sel];
            py  = vy[sel];
         end
         2: begin
            sel = $urandom_range(0, n - 1);
            px  = near(vx[sel]);
            py  = near(vy[sel]);
         end
         default: begin
            px = vx[$urandom_range(0, n - 1)];
            py = near(vy[$urandom_range(0, n - 1)]);
         end
      endcase
      // now and then the point moves part way through the polygon
      hop = ($urandom_range(0, 19) == 0) ? $urandom_range(0, n - 1) : -1;
      for (int i = 0; i < n; i++) begin
         if (i == hop) begin
            px = rand_coord(span);
            py = rand_coord(span);
         end
         add_vertex(px, py, vx[i], vy[i],
                    (i == 0) ? ($urandom_range(0, 9) != 0) : 1'b0, i == n - 1);
      end
   endtask

   // burst of items with random marks
   task automatic add_noise();
      int n, span;
      n    = $urandom_range(1, 6);
      span = ($urandom_range(0, 1) == 0) ? 64 : 0;
      for (int i = 0; i < n; i++)
         add_vertex(rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span),
                    $urandom_range(0, 1), $urandom_range(0, 1));
   endtask

   // directed cases, random polygons, then the end of the run
   initial begin
      // triangle, point inside
      add_vertex(32, 32, 0, 0, 1, 0);
      add_vertex(32, 32, 160, 0, 0, 0);
      add_vertex(32, 32, 0, 160, 0, 1);
      // same triangle, point on a vertex
      add_vertex(160, 0, 0, 0, 1, 0);
      add_vertex(160, 0, 160, 0, 0, 0);
      add_vertex(160, 0, 0, 160, 0, 1);
      // square, point inside a horizontal edge
      add_vertex(32, 0, 0, 0, 1, 0);
      add_vertex(32, 0, 64, 0, 0, 0);
      add_vertex(32, 0, 64, 64, 0, 0);
      add_vertex(32, 0, 0, 64, 0, 1);
      // square, point inside the vertical closing edge
      add_vertex(0, 32, 0, 0, 1, 0);
      add_vertex(0, 32, 64, 0, 0, 0);
      add_vertex(0, 32, 64, 64, 0, 0);
      add_vertex(0, 32, 0, 64, 0, 1);
      // one vertex with both marks, then a two-vertex polygon
      add_vertex(7, 7, 7, 7, 1, 1);
      add_vertex(1, 1, 0, 0, 1, 0);
      add_vertex(1, 1, 8, 8, 0, 1);
      // no polygon open: opens without a first mark, extreme vertices, point moves
      add_vertex(0, 0, -32768, -32768, 0, 0);
      add_vertex(0, 0, 32767, -32768, 0, 0);
      add_vertex(-1, -1, 0, 32767, 0, 1);
      // restart part way, extreme point outside
      add_vertex(32767, -32768, 5, 5, 1, 0);
      add_vertex(32767, -32768, -100, -100, 1, 0);
      add_vertex(32767, -32768, 100, -100, 0, 0);
      add_vertex(-32768, 32767, 0, 100, 0, 1);
      while (vertex_q.size() < ITEM_TOTAL) begin
         if ($urandom_range(0, 9) == 0) add_noise();
         else                           add_polygon();
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      while (vertex_q.size() > 0 || req_tvalid || verdict_q.size() > 0)
         @(negedge clock);
      repeat (END_PAUSE) @(posedge clock);
      if (fail_cnt == 0 && verdict_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // driver: predicts on each accepted transfer, then offers the next vertex
   always @(posedge clock) begin : driver
      vertex_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            polygon_vertex_accept(req_tdata[COORD_WIDTH-1:0],
                                  req_tdata[2*COORD_WIDTH-1:COORD_WIDTH],
                                  req_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH],
                                  req_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH],
                                  req_tuser, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (vertex_q.size() > 0 && !idle_now()) begin
               it = vertex_q.pop_front();
               req_tdata  <= REQ_DATA_W'({it.vy, it.vx, it.py, it.px});
               req_tuser  <= it.first;
               req_tlast  <= it.last;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic want, input logic got);
      if (want !== got) begin
         $error("%s: expected %0b, got %0b", name, want, got);
         fail_cnt++;
      end
   endtask

   // monitor: compares each result transfer with the oldest verdict
   always @(posedge clock) begin : monitor
      verdict_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = verdict_type'(rsp_tdata[RSP_FIELD_W-1:0]);
            if (verdict_q.size() == 0) begin
               $error("result transfer with no verdict waiting: %b", got);
               fail_cnt++;
            end else begin
               want = verdict_q.pop_front();
               check_field("inside_res", want.in_poly, got.in_poly);
               check_field("on_boundary", want.on_bnd, got.on_bnd);
               check_field("too_few_vertices", want.too_few, got.too_few);
            end
         end
         rsp_tready <= !idle_now();
      end
   end

   // watchdog: cycles with work outstanding but no transfer on either side
   always @(posedge clock) begin : watchdog
      cycle_cnt <= cycle_cnt + 1;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cnt <= 0;
      end else if (vertex_q.size() > 0 || req_tvalid || verdict_q.size() > 0) begin
         if (stall_cnt >= STALL_MAX) begin
            $display("simulation failed");
            $finish;
         end else begin
            stall_cnt <= stall_cnt + 1;
         end
      end
   end

endmodule

/* files.f */
rtl/ppct_pkg.sv
rtl/polygon_point_crossing_test.sv
rtl/ppct_checker.sv
tb/tb.sv
